@@ src/hsrt_pkg.sv @@
// Shared constants and types of the hashed search result table.
package hsrt_pkg;

    localparam int INDEX_BITS = 10;
    localparam int GEN_BITS   = 8;
    localparam int SLOT_COUNT = 1 << INDEX_BITS;

    localparam logic [GEN_BITS-1:0] GEN_ONE   = GEN_BITS'(1);
    localparam logic [GEN_BITS-1:0] AGE_LIMIT = GEN_BITS'(4);

    localparam logic [1:0] MODE_STORE      = 2'd0;
    localparam logic [1:0] MODE_PROBE      = 2'd1;
    localparam logic [1:0] MODE_NEW_SEARCH = 2'd2;

    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [GEN_BITS-1:0]   gen_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [63:0]        key;
        logic [7:0]         depth;
        logic signed [15:0] score;
        logic [1:0]         bound;
        logic [15:0]        move;
    } item_t;

    typedef struct packed {
        logic [63:0]        key;
        logic [7:0]         depth;
        logic signed [15:0] score;
        logic [1:0]         bound;
        logic [15:0]        move;
        gen_t               gen;
    } slot_t;

    typedef struct packed {
        logic               hit;
        logic [7:0]         depth;
        logic signed [15:0] score;
        logic [1:0]         bound;
        logic [15:0]        move;
    } result_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

endpackage

@@ src/hsrt_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
module hsrt_ram #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [1 << ADDR_BITS];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/hsrt_slot_logic.sv @@
// Replacement and hit decision for one slot access.
module hsrt_slot_logic (
    input  hsrt_pkg::item_t   item,
    input  hsrt_pkg::slot_t   cur,
    input  hsrt_pkg::gen_t    gen,
    output hsrt_pkg::slot_t   new_slot,
    output logic              write_en,
    output hsrt_pkg::result_t result
);

    hsrt_pkg::gen_t age;
    logic           key_match;

    assign age       = gen - cur.gen;
    assign key_match = (cur.key == item.key);

    always_comb begin
        new_slot.key   = item.key;
        new_slot.depth = item.depth;
        new_slot.score = item.score;
        new_slot.bound = item.bound;
        new_slot.move  = item.move;
        new_slot.gen   = gen;
        write_en       = 1'b0;
        result         = '0;
        case (item.mode)
            hsrt_pkg::MODE_STORE: begin
                write_en = !key_match || (age >= hsrt_pkg::AGE_LIMIT) ||
                           (cur.depth <= item.depth);
            end
            hsrt_pkg::MODE_PROBE: begin
                if (key_match && (age <= hsrt_pkg::AGE_LIMIT) && (cur.depth >= item.depth)) begin
                    result.hit   = 1'b1;
                    result.depth = cur.depth;
                    result.score = cur.score;
                    result.bound = cur.bound;
                    result.move  = cur.move;
                end
            end
            default: begin
                write_en = 1'b0;
            end
        endcase
    end

endmodule

@@ src/hashed_search_result_table.sv @@
// Top level of the hashed search result table.
//
// Input channel s_*: one beat per operation (store, probe, new search) with
// key, depth, score, bound and move. Output channel m_*: exactly one result
// beat per input beat, in order; hit and the stored fields on a probe hit,
// all zero otherwise.
// Timing: the slot read is registered at the accepting edge; decision, write
// back and the result register follow when the decision stage advances,
// which waits while a held result is not taken by m_ready.
// Throughput: one beat per cycle while m_ready is high, set by the single read
// and write port of the slot memory; a write to the slot read in the same cycle is forwarded.
// Reset: the generation clears and a clearing pass writes zero to every slot,
// one per cycle, all 2^INDEX_BITS (1024) of them; s_ready stays low meanwhile.
// Stall: while m_ready is low the result holds; one further beat is accepted
// and waits in the decision stage, then s_ready drops until the result drains.
module hashed_search_result_table (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [63:0]        s_key,
    input  logic [7:0]         s_depth,
    input  logic signed [15:0] s_score,
    input  logic [1:0]         s_bound,
    input  logic [15:0]        s_move,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic [7:0]         m_out_depth,
    output logic signed [15:0] m_out_score,
    output logic [1:0]         m_out_bound,
    output logic [15:0]        m_out_move
);

    localparam int SLOT_BITS = $bits(hsrt_pkg::slot_t);

    hsrt_pkg::state_t  state_reg, state_next;
    hsrt_pkg::index_t  clr_cnt_reg, clr_cnt_next;
    logic              s1_valid_reg;
    hsrt_pkg::item_t   s1_item_reg;
    logic              fwd_hit_reg;
    hsrt_pkg::slot_t   fwd_slot_reg;
    hsrt_pkg::gen_t    gen_reg, gen_next;
    logic              m_valid_reg;
    hsrt_pkg::result_t m_res_reg;

    hsrt_pkg::item_t   in_item;
    hsrt_pkg::index_t  in_idx, s1_idx;
    logic              clearing, accept, s1_adv, run_we;
    logic              mem_we;
    hsrt_pkg::index_t  mem_waddr;
    hsrt_pkg::slot_t   mem_wdata;
    logic [SLOT_BITS-1:0] ram_rdata;
    hsrt_pkg::slot_t   cur_slot, new_slot;
    logic              write_en;
    hsrt_pkg::result_t result;

    assign in_item.mode  = s_mode;
    assign in_item.key   = s_key;
    assign in_item.depth = s_depth;
    assign in_item.score = s_score;
    assign in_item.bound = s_bound;
    assign in_item.move  = s_move;

    assign in_idx   = s_key[hsrt_pkg::INDEX_BITS-1:0];
    assign s1_idx   = s1_item_reg.key[hsrt_pkg::INDEX_BITS-1:0];
    assign clearing = (state_reg == hsrt_pkg::ST_CLEAR);
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !clearing && (!s1_valid_reg || s1_adv);
    assign accept   = s_valid && s_ready;
    assign run_we   = s1_adv && write_en;

    assign mem_we    = clearing || run_we;
    assign mem_waddr = clearing ? clr_cnt_reg : s1_idx;
    assign mem_wdata = clearing ? '0 : new_slot;

    hsrt_ram #(
        .ADDR_BITS(hsrt_pkg::INDEX_BITS),
        .DATA_BITS(SLOT_BITS)
    ) u_ram (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (accept),
        .raddr(in_idx),
        .rdata(ram_rdata)
    );

    assign cur_slot = fwd_hit_reg ? fwd_slot_reg : hsrt_pkg::slot_t'(ram_rdata);

    hsrt_slot_logic u_slot_logic (
        .item    (s1_item_reg),
        .cur     (cur_slot),
        .gen     (gen_reg),
        .new_slot(new_slot),
        .write_en(write_en),
        .result  (result)
    );

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            hsrt_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + hsrt_pkg::index_t'(1);
                if (clr_cnt_reg == '1) begin
                    state_next = hsrt_pkg::ST_RUN;
                end
            end
            hsrt_pkg::ST_RUN: begin
                state_next = hsrt_pkg::ST_RUN;
            end
            default: begin
                state_next = hsrt_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        gen_next = gen_reg;
        if (s1_adv && (s1_item_reg.mode == hsrt_pkg::MODE_NEW_SEARCH)) begin
            gen_next = gen_reg + hsrt_pkg::GEN_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hsrt_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            gen_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            gen_reg     <= gen_next;
            if (accept) begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= run_we && (s1_idx == in_idx);
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg  <= in_item;
            fwd_slot_reg <= new_slot;
        end
        if (s1_adv) begin
            m_res_reg <= result;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = m_res_reg.hit;
    assign m_out_depth = m_res_reg.depth;
    assign m_out_score = m_res_reg.score;
    assign m_out_bound = m_res_reg.bound;
    assign m_out_move  = m_res_reg.move;

`ifndef SYNTHESIS
    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s1_valid_reg && !s_ready)
        else $error("decision stage busy during clearing pass");

    a_accept_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s1_valid_reg |-> s1_adv)
        else $error("beat accepted over a stalled decision stage");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> (m_out_depth == 8'd0) && (m_out_score == 16'sd0) &&
        (m_out_bound == 2'd0) && (m_out_move == 16'd0))
        else $error("nonzero fields on a miss result");

    a_fwd_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv && !write_en |=> !mem_we || (mem_waddr == s1_idx))
        else $error("unexpected memory write");
`endif

endmodule
